// ===== design/cct_pkg.sv =====
// cct_pkg: shared widths, codes and item layouts of the compensated cook timer
// used by cct_div and compensated_multi_phase_cook_timer; no dependencies
package cct_pkg;

    // port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 48;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 48;

    // datapath widths
    localparam int PROG_W = 48;   // cook and rest progress
    localparam int TGT_W  = 42;   // side target, sec * factor * 1000
    localparam int K_W    = 15;   // rate factor, q1.14
    localparam int REM_W  = 20;
    localparam int DIV_NW = 49;   // widest dividend: progress * 100 below target
    localparam int DIV_DW = 42;   // widest divisor: side target

    localparam logic [K_W-1:0]   K_ONE   = 15'd16384;
    localparam logic [K_W-1:0]   K_MIN   = 15'd11469;
    localparam logic [K_W-1:0]   K_MAX   = 15'd21299;
    localparam logic [REM_W-1:0] REM_MAX = 20'hFFFFF;
    localparam int               MAX_SIDES = 2;

    typedef enum logic [1:0] {
        FN_UPDATE = 2'd0,
        FN_START  = 2'd1,
        FN_STOP   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_COOK = 2'd1,
        PH_REST = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_FLIP     = 2'd1,
        EV_REMOVE   = 2'd2,
        EV_REST_END = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMP_PCT    = 3'd0,
        CFG_REF_TEMP    = 3'd1,
        CFG_SIDE_COUNT  = 3'd2,
        CFG_SIDE_ONE    = 3'd3,
        CFG_SIDE_TWO    = 3'd4,
        CFG_REST_SEC    = 3'd5,
        CFG_TIME_FACTOR = 3'd6
    } cfg_idx_t;

    // result item, phase in the lowest bits
    typedef struct packed {
        logic [K_W-1:0]   comp_factor;
        logic [6:0]       progress_pct;
        logic [REM_W-1:0] remaining_sec;
        logic [1:0]       side_number;
        event_t           event_res;
        phase_t           phase;
    } res_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/cct_div.sv =====
// cct_div: restoring unsigned divider, one quotient bit per cycle
// depends on cct_pkg for widths and the request and response structs
module cct_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cct_pkg::div_req_t req,
    output cct_pkg::div_rsp_t rsp
);
    import cct_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   trial;

    assign shifted = {rem_reg, quo_reg[DIV_NW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_NW);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            // no borrow means the shifted remainder covers the divisor
            if (!trial[DIV_DW]) begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/compensated_multi_phase_cook_timer.sv =====
// compensated_multi_phase_cook_timer: sequencer, shared multiplier and timer state
// depends on cct_pkg and instantiates the shared divider cct_div
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------------
//  cfg      | in        | cfg_index selects register, cfg_wdata holds the value
//  s_       | in        | tuser: func; tdata: now_ms, pan_temp
//  m_       | out       | tdata: phase, event_res, side_number, remaining_sec,
//           |           |        progress_pct, comp_factor
//
// start, stop, func 3 and updates while idle or done go straight to ST_OUT, which raises
// m_tvalid. a resting update runs ST_REST, ST_RCHK and ST_RQUO (ST_RQUO is skipped when
// the rest ends): reciprocal multiply, no divider. a cooking update runs the rate factor
// and target states (the target states again on a flip), then two 49-step divider passes
// (remaining time, percent); a removal or a reached target skips the divider. s_tready is
// low from accept until the result moves to the output register; a stalled m_ side holds
// the sequencer in its last state. reset is synchronous.
module compensated_multi_phase_cook_timer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cct_pkg::S_DATA_W-1:0]    s_tdata,   // now_ms, pan_temp, pad
    input  logic [cct_pkg::S_USER_W-1:0]    s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cct_pkg::M_DATA_W-1:0]    m_tdata    // phase, event_res, side_number,
                                                       // remaining_sec, progress_pct,
                                                       // comp_factor
);
    import cct_pkg::*;

    // any larger |d| saturates the rate factor
    localparam logic [22:0] D_SAT      = 23'd7501;
    // rounding term 12500 divided by 8, fits below the shifted d
    localparam logic [10:0] K_BIAS     = 11'd1562;
    // ceil(2^36 / 3125), exact for dividends below 2^24
    localparam logic [31:0] RECIP_3125 = 32'd21990233;
    // ceil(2^30 / 125), exact for dividends below 2^23
    localparam logic [31:0] RECIP_125  = 32'd8589935;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REST,
        ST_RCHK,
        ST_RQUO,
        ST_KDIFF,
        ST_KMUL,
        ST_KDIV,
        ST_KCLAMP,
        ST_CMUL,
        ST_CADD,
        ST_T1,
        ST_T2,
        ST_CHECK,
        ST_REMK,
        ST_RDIV,
        ST_RDWAIT,
        ST_PCT,
        ST_PWAIT,
        ST_OUT
    } state_t;

    // configuration
    logic [7:0]  comp_pct_reg;
    logic [9:0]  ref_temp_reg;
    logic [1:0]  side_count_reg;
    logic [15:0] side_one_reg;
    logic [15:0] side_two_reg;
    logic [15:0] rest_sec_reg;
    logic [15:0] time_factor_reg;

    // control and timer state
    state_t             state_reg, state_next;
    logic               m_tvalid_reg, m_tvalid_next;
    res_t               m_tdata_reg, m_tdata_next;
    logic               running_reg, running_next;
    logic               finished_reg, finished_next;
    logic               in_rest_reg, in_rest_next;
    logic               side_idx_reg, side_idx_next;
    logic [31:0]        last_stamp_reg, last_stamp_next;
    logic [PROG_W-1:0]  cook_reg, cook_next;
    logic [PROG_W-1:0]  rest_reg, rest_next;

    // working registers
    res_t               res_reg, res_next;
    logic [31:0]        dt_reg, dt_next;
    logic [14:0]        pan_reg, pan_next;
    logic [15:0]        diff_mag_reg, diff_mag_next;
    logic               diff_neg_reg, diff_neg_next;
    logic [22:0]        d_mag_reg, d_mag_next;
    logic               d_neg_reg, d_neg_next;
    logic [12:0]        kq_reg, kq_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [46:0]        prod_reg, prod_next;
    logic [TGT_W-1:0]   target_reg, target_next;
    logic [24:0]        kd_reg, kd_next;
    logic [25:0]        rest_ms_reg, rest_ms_next;
    logic               flipped_reg, flipped_next;

    // datapath signals
    logic [31:0]        in_now;
    logic [14:0]        in_pan;
    func_t              in_func;
    phase_t             cur_phase;
    logic [1:0]         sides_eff;
    logic               last_side;
    logic               reached;
    logic               rest_hit;
    logic [15:0]        tf_eff;
    logic [15:0]        sec_sel;
    logic [PROG_W:0]    cook_sum;
    logic [PROG_W:0]    rest_sum;
    logic [13:0]        ref_x10;
    logic [16:0]        diff;
    logic [7:0]         pct_mag;
    logic [12:0]        d_lim;
    logic [K_W-1:0]     k_lo;
    logic [K_W-1:0]     k_hi;
    logic [REM_W-1:0]   rem_q_sat;
    logic [DIV_NW-1:0]  cook_x100;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    cct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_pct_reg    <= 8'd0;
            ref_temp_reg    <= 10'd350;
            side_count_reg  <= 2'd1;
            side_one_reg    <= 16'd0;
            side_two_reg    <= 16'd0;
            rest_sec_reg    <= 16'd0;
            time_factor_reg <= 16'(K_ONE);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_COMP_PCT:    comp_pct_reg    <= cfg_wdata[7:0];
                CFG_REF_TEMP:    ref_temp_reg    <= cfg_wdata[9:0];
                CFG_SIDE_COUNT:  side_count_reg  <= cfg_wdata[1:0];
                CFG_SIDE_ONE:    side_one_reg    <= cfg_wdata;
                CFG_SIDE_TWO:    side_two_reg    <= cfg_wdata;
                CFG_REST_SEC:    rest_sec_reg    <= cfg_wdata;
                CFG_TIME_FACTOR: time_factor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_now  = s_tdata[31:0];
    assign in_pan  = s_tdata[46:32];
    assign in_func = func_t'(s_tuser);

    assign cur_phase = !running_reg ? PH_IDLE :
                       finished_reg ? PH_DONE :
                       in_rest_reg  ? PH_REST : PH_COOK;

    assign sides_eff = (side_count_reg == 2'd0) ? 2'd1 :
                       (side_count_reg > 2'(MAX_SIDES)) ? 2'(MAX_SIDES) : side_count_reg;
    assign last_side = ({1'b0, side_idx_reg} + 2'd1) >= sides_eff;
    assign reached   = cook_reg >= {{(PROG_W-TGT_W){1'b0}}, target_reg};
    assign rest_hit  = rest_reg >= {{(PROG_W-26){1'b0}}, rest_ms_reg};
    assign tf_eff    = (time_factor_reg == 16'd0) ? 16'(K_ONE) : time_factor_reg;
    assign sec_sel   = side_idx_reg ? side_two_reg : side_one_reg;

    assign cook_sum = {1'b0, cook_reg} + {{(PROG_W-46){1'b0}}, prod_reg};
    assign rest_sum = {1'b0, rest_reg} + {{(PROG_W-31){1'b0}}, dt_reg};

    // reference in tenths minus pan temperature, sign and magnitude
    assign ref_x10 = {1'b0, ref_temp_reg, 3'b000} + {3'b000, ref_temp_reg, 1'b0};
    assign diff    = {3'b000, ref_x10} - {{2{pan_reg[14]}}, pan_reg};
    assign pct_mag = comp_pct_reg[7] ? (8'd0 - comp_pct_reg) : comp_pct_reg;

    // q = floor((|d|*16384 + 12500) / 25000) = floor((|d|*2048 + 1562) / 3125);
    // the sum is never a multiple of 25000, so q is also the ceiling a negative d needs
    assign d_lim = (d_mag_reg >= D_SAT) ? D_SAT[12:0] : d_mag_reg[12:0];
    assign k_lo  = (kq_reg > 13'(K_ONE - K_MIN)) ? K_MIN : K_ONE - K_W'(kq_reg);
    assign k_hi  = (kq_reg > 13'(K_MAX - K_ONE)) ? K_MAX : K_ONE + K_W'(kq_reg);

    assign rem_q_sat = (|div_rsp.quotient[DIV_NW-1:REM_W]) ? REM_MAX :
                       div_rsp.quotient[REM_W-1:0];

    // only used below the target, so the product fits the dividend
    assign cook_x100 = DIV_NW'({cook_reg, 6'b0}) + DIV_NW'({cook_reg, 5'b0}) +
                       DIV_NW'({cook_reg, 2'b0});

    // shared multiplier operands
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_REST: begin
                mul_a = {16'd0, rest_sec_reg};
                mul_b = 32'd1000;
            end
            ST_RQUO: begin
                // remaining rest ms over 1000 as (ms / 8) / 125
                mul_a = {9'd0, rest_ms_reg[25:3]};
                mul_b = RECIP_125;
            end
            ST_KMUL: begin
                mul_a = {24'd0, pct_mag};
                mul_b = {16'd0, diff_mag_reg};
            end
            ST_KDIV: begin
                mul_a = {8'd0, d_lim, K_BIAS};
                mul_b = RECIP_3125;
            end
            ST_CMUL: begin
                mul_a = dt_reg;
                mul_b = {17'd0, k_reg};
            end
            ST_T1: begin
                mul_a = {16'd0, sec_sel};
                mul_b = {16'd0, tf_eff};
            end
            ST_T2: begin
                mul_a = prod_reg[31:0];
                mul_b = 32'd1000;
            end
            ST_REMK: begin
                mul_a = {17'd0, k_reg};
                mul_b = 32'd1000;
            end
            default: ;
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // shared divider requests
    always_comb begin
        div_req = '0;
        case (state_reg)
            ST_RDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(target_reg - cook_reg[TGT_W-1:0]);
                div_req.divisor  = DIV_DW'(kd_reg);
            end
            ST_PCT: begin
                div_req.start    = (target_reg != '0) && !reached;
                div_req.dividend = cook_x100;
                div_req.divisor  = target_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        running_next    = running_reg;
        finished_next   = finished_reg;
        in_rest_next    = in_rest_reg;
        side_idx_next   = side_idx_reg;
        last_stamp_next = last_stamp_reg;
        cook_next       = cook_reg;
        rest_next       = rest_reg;
        res_next        = res_reg;
        dt_next         = dt_reg;
        pan_next        = pan_reg;
        diff_mag_next   = diff_mag_reg;
        diff_neg_next   = diff_neg_reg;
        d_mag_next      = d_mag_reg;
        d_neg_next      = d_neg_reg;
        kq_next         = kq_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        target_next     = target_reg;
        kd_next         = kd_reg;
        rest_ms_next    = rest_ms_reg;
        flipped_next    = flipped_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_next     = '0;
                    flipped_next = 1'b0;
                    state_next   = ST_OUT;
                    case (in_func)
                        FN_START: begin
                            running_next    = 1'b1;
                            finished_next   = 1'b0;
                            in_rest_next    = 1'b0;
                            side_idx_next   = 1'b0;
                            last_stamp_next = in_now;
                            cook_next       = '0;
                            rest_next       = '0;
                            res_next.phase  = PH_COOK;
                        end
                        FN_STOP: begin
                            running_next   = 1'b0;
                            finished_next  = 1'b0;
                            res_next.phase = PH_IDLE;
                        end
                        FN_UPDATE: begin
                            if (!running_reg || finished_reg) begin
                                res_next.phase = cur_phase;
                            end else begin
                                // a timestamp that went backward counts as no time
                                dt_next = (in_now >= last_stamp_reg) ?
                                          in_now - last_stamp_reg : 32'd0;
                                last_stamp_next = in_now;
                                pan_next        = in_pan;
                                if (in_rest_reg) begin
                                    res_next.phase = PH_REST;
                                    state_next     = ST_REST;
                                end else begin
                                    res_next.phase = PH_COOK;
                                    state_next     = ST_KDIFF;
                                end
                            end
                        end
                        default: begin
                            res_next.phase = cur_phase;
                        end
                    endcase
                end
            end

            ST_REST: begin
                rest_ms_next = mul_p[25:0];
                rest_next    = rest_sum[PROG_W] ? {PROG_W{1'b1}} : rest_sum[PROG_W-1:0];
                state_next   = ST_RCHK;
            end

            ST_RCHK: begin
                if (rest_hit) begin
                    in_rest_next       = 1'b0;
                    finished_next      = 1'b1;
                    res_next.phase     = PH_DONE;
                    res_next.event_res = EV_REST_END;
                    state_next         = ST_OUT;
                end else begin
                    // keep the remaining rest ms for the quotient
                    rest_ms_next = rest_ms_reg - rest_reg[25:0];
                    state_next   = ST_RQUO;
                end
            end

            ST_RQUO: begin
                res_next.remaining_sec = {4'd0, mul_p[45:30]};
                state_next             = ST_OUT;
            end

            ST_KDIFF: begin
                diff_neg_next = diff[16];
                diff_mag_next = diff[16] ? 16'(17'd0 - diff) : diff[15:0];
                state_next    = ST_KMUL;
            end

            ST_KMUL: begin
                d_mag_next = mul_p[22:0];
                d_neg_next = (comp_pct_reg[7] ^ diff_neg_reg) && (mul_p[22:0] != 23'd0);
                state_next = ST_KDIV;
            end

            ST_KDIV: begin
                kq_next    = mul_p[48:36];
                state_next = ST_KCLAMP;
            end

            ST_KCLAMP: begin
                k_next     = d_neg_reg ? k_lo : k_hi;
                state_next = ST_CMUL;
            end

            ST_CMUL: begin
                prod_next  = mul_p[46:0];
                state_next = ST_CADD;
            end

            ST_CADD: begin
                cook_next  = cook_sum[PROG_W] ? {PROG_W{1'b1}} : cook_sum[PROG_W-1:0];
                state_next = ST_T1;
            end

            ST_T1: begin
                prod_next  = {15'd0, mul_p[31:0]};
                state_next = ST_T2;
            end

            ST_T2: begin
                target_next = mul_p[TGT_W-1:0];
                state_next  = ST_CHECK;
            end

            ST_CHECK: begin
                if (flipped_reg || !reached) begin
                    state_next = ST_REMK;
                end else if (!last_side) begin
                    // flip: fetch the next side's target, then report on it
                    res_next.event_res = EV_FLIP;
                    side_idx_next      = !side_idx_reg;
                    cook_next          = '0;
                    flipped_next       = 1'b1;
                    state_next         = ST_T1;
                end else begin
                    res_next.event_res     = EV_REMOVE;
                    res_next.side_number   = {1'b0, side_idx_reg} + 2'd1;
                    res_next.remaining_sec = '0;
                    res_next.progress_pct  = 7'd100;
                    res_next.comp_factor   = k_reg;
                    if (rest_sec_reg != 16'd0) begin
                        in_rest_next = 1'b1;
                        rest_next    = '0;
                    end else begin
                        finished_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end

            ST_REMK: begin
                res_next.side_number = {1'b0, side_idx_reg} + 2'd1;
                res_next.comp_factor = k_reg;
                kd_next              = mul_p[24:0];
                if (!reached) begin
                    state_next = ST_RDIV;
                end else begin
                    res_next.remaining_sec = '0;
                    state_next             = ST_PCT;
                end
            end

            ST_RDIV: begin
                state_next = ST_RDWAIT;
            end

            ST_RDWAIT: begin
                if (div_rsp.done) begin
                    res_next.remaining_sec = rem_q_sat;
                    state_next             = ST_PCT;
                end
            end

            ST_PCT: begin
                if (target_reg == '0) begin
                    res_next.progress_pct = 7'd0;
                    state_next            = ST_OUT;
                end else if (reached) begin
                    res_next.progress_pct = 7'd100;
                    state_next            = ST_OUT;
                end else begin
                    state_next = ST_PWAIT;
                end
            end

            ST_PWAIT: begin
                if (div_rsp.done) begin
                    res_next.progress_pct = div_rsp.quotient[6:0];
                    state_next            = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            running_reg    <= 1'b0;
            finished_reg   <= 1'b0;
            in_rest_reg    <= 1'b0;
            side_idx_reg   <= 1'b0;
            last_stamp_reg <= 32'd0;
            cook_reg       <= '0;
            rest_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            running_reg    <= running_next;
            finished_reg   <= finished_next;
            in_rest_reg    <= in_rest_next;
            side_idx_reg   <= side_idx_next;
            last_stamp_reg <= last_stamp_next;
            cook_reg       <= cook_next;
            rest_reg       <= rest_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        dt_reg       <= dt_next;
        pan_reg      <= pan_next;
        diff_mag_reg <= diff_mag_next;
        diff_neg_reg <= diff_neg_next;
        d_mag_reg    <= d_mag_next;
        d_neg_reg    <= d_neg_next;
        kq_reg       <= kq_next;
        k_reg        <= k_next;
        prod_reg     <= prod_next;
        target_reg   <= target_next;
        kd_reg       <= kd_next;
        rest_ms_reg  <= rest_ms_next;
        flipped_reg  <= flipped_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the sequencer never restarts the divider in the middle of a pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // done needs a running timer, and rest and done never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> (running_reg && !in_rest_reg))
        else $error("done flag without running timer or with rest");

    // the clamped rate factor reaches the progress multiply
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMUL) |-> (k_reg >= K_MIN && k_reg <= K_MAX))
        else $error("rate factor out of clamp range");

    // a second pass over the target check only follows a flip to the second side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && flipped_reg) |-> side_idx_reg)
        else $error("flip left the first side selected");

    // a rate factor is reported only with a cooking phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg.comp_factor != '0) |-> (m_tdata_reg.phase == PH_COOK))
        else $error("rate factor reported outside cooking");

endmodule
